// ----- design/sclx_pkg.sv -----
// ----------------------------------------------------------------------------
// Script lexer package
// Shared types and constants for the byte-stream script lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package sclx_pkg;

   typedef enum logic [3:0] {
      KIND_ERROR     = 4'd0,
      KIND_START     = 4'd1,
      KIND_END       = 4'd2,
      KIND_VARIABLE  = 4'd3,
      KIND_LPAREN    = 4'd4,
      KIND_RPAREN    = 4'd5,
      KIND_STRING    = 4'd6,
      KIND_NUMBER    = 4'd7,
      KIND_LSQUARE   = 4'd8,
      KIND_RSQUARE   = 4'd9,
      KIND_SEMICOLON = 4'd10
   } token_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_UNKNOWN    = 2'd1,
      ERR_UNTERMINATED = 2'd2
   } error_code_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_TOP    = 3'd1,
      MODE_NUMBER = 3'd2,
      MODE_WORD   = 3'd3,
      MODE_DOLLAR = 3'd4
   } lex_mode_type;

   // Character codes.
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_LT      = 8'h3C;
   localparam logic [7:0] CHAR_AT      = 8'h40;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LSQUARE = 8'h5B;
   localparam logic [7:0] CHAR_RSQUARE = 8'h5D;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   // Result queue depth; a byte can push two tokens at once.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_BITS = 2;
   localparam int unsigned QUEUE_CNT_BITS = 3;

   typedef struct packed {
      token_kind_type kind;
      logic [31:0]    number_value;
      logic [15:0]    text_start;
      logic [15:0]    text_end;
      error_code_type error_code;
      logic [7:0]     bad_char;
      logic           last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

// ----- design/sclx_lexer.sv -----
// ----------------------------------------------------------------------------
// Script lexer core
// Holds the lexer state and turns one program byte into up to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module sclx_lexer #(
   parameter int unsigned POSITION_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_accept,
   input  wire logic [7:0]         in_byte,
   output sclx_pkg::push_type      push
);

   sclx_pkg::lex_mode_type     mode_ff, mode_in;
   logic [31:0]                accum_ff, accum_in;
   logic [POSITION_BITS-1:0]   text_begin_ff, text_begin_in;
   logic [POSITION_BITS-1:0]   position_ff, position_in;
   logic                       is_variable_ff, is_variable_in;
   logic                       is_quoted_ff, is_quoted_in;

   logic [POSITION_BITS-1:0]   pos;
   logic                       is_digit;
   logic                       do_word;
   logic                       do_classify;
   logic                       pre_valid;
   logic                       cls_valid;
   sclx_pkg::result_type       pre_rec;
   sclx_pkg::result_type       cls_rec;
   sclx_pkg::token_kind_type   word_kind;

   function automatic logic is_word_byte(input logic [7:0] c, input logic digits_ok);
      return (c >= sclx_pkg::CHAR_LOWER_A && c <= sclx_pkg::CHAR_LOWER_Z) ||
             (c >= sclx_pkg::CHAR_UPPER_A && c <= sclx_pkg::CHAR_UPPER_Z) ||
             (c >= sclx_pkg::CHAR_PERCENT && c <= sclx_pkg::CHAR_SLASH &&
              c != sclx_pkg::CHAR_LPAREN && c != sclx_pkg::CHAR_RPAREN) ||
             (c == sclx_pkg::CHAR_COLON) ||
             (c >= sclx_pkg::CHAR_LT && c <= sclx_pkg::CHAR_AT) ||
             (digits_ok && c >= sclx_pkg::CHAR_ZERO && c <= sclx_pkg::CHAR_NINE);
   endfunction

   function automatic logic [15:0] offset16(input logic [POSITION_BITS-1:0] p);
      logic [POSITION_BITS+15:0] wide;
      wide = {16'b0, p};
      return wide[15:0];
   endfunction

   function automatic sclx_pkg::result_type make_rec(
      input sclx_pkg::token_kind_type kind,
      input logic [31:0]              num,
      input logic [15:0]              ts,
      input logic [15:0]              te,
      input sclx_pkg::error_code_type err,
      input logic [7:0]               bad
   );
      sclx_pkg::result_type r;
      r.kind         = kind;
      r.number_value = num;
      r.text_start   = ts;
      r.text_end     = te;
      r.error_code   = err;
      r.bad_char     = bad;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   assign is_digit = (in_byte >= sclx_pkg::CHAR_ZERO) && (in_byte <= sclx_pkg::CHAR_NINE);

   always_comb begin
      mode_in        = mode_ff;
      accum_in       = accum_ff;
      text_begin_in  = text_begin_ff;
      is_variable_in = is_variable_ff;
      is_quoted_in   = is_quoted_ff;
      pos            = position_ff;
      do_word        = 1'b0;
      do_classify    = 1'b0;
      pre_valid      = 1'b0;
      cls_valid      = 1'b0;
      pre_rec        = make_rec(sclx_pkg::KIND_ERROR, 32'd0, 16'd0, 16'd0,
                                sclx_pkg::ERR_NONE, 8'd0);
      cls_rec        = pre_rec;
      word_kind      = sclx_pkg::KIND_STRING;

      case (mode_ff)
         sclx_pkg::MODE_IDLE: begin
            pos            = '0;
            accum_in       = 32'd0;
            is_variable_in = 1'b0;
            is_quoted_in   = 1'b0;
            pre_valid      = 1'b1;
            pre_rec        = make_rec(sclx_pkg::KIND_START, 32'd0, 16'd0, 16'd0,
                                      sclx_pkg::ERR_NONE, 8'd0);
            mode_in        = sclx_pkg::MODE_TOP;
            do_classify    = 1'b1;
         end
         sclx_pkg::MODE_NUMBER: begin
            if (is_digit) begin
               accum_in = {accum_ff[28:0], 3'b000} + {accum_ff[30:0], 1'b0} +
                          {28'd0, in_byte[3:0]};
            end else begin
               pre_valid   = 1'b1;
               pre_rec     = make_rec(sclx_pkg::KIND_NUMBER, accum_ff, 16'd0, 16'd0,
                                      sclx_pkg::ERR_NONE, 8'd0);
               mode_in     = sclx_pkg::MODE_TOP;
               do_classify = 1'b1;
            end
         end
         sclx_pkg::MODE_WORD: begin
            do_word = 1'b1;
         end
         sclx_pkg::MODE_DOLLAR: begin
            mode_in = sclx_pkg::MODE_WORD;
            if (in_byte == sclx_pkg::CHAR_QUOTE) begin
               is_quoted_in  = 1'b1;
               text_begin_in = position_ff + 1'b1;
            end else begin
               is_quoted_in  = 1'b0;
               text_begin_in = position_ff;
               do_word       = 1'b1;
            end
         end
         sclx_pkg::MODE_TOP: begin
            do_classify = 1'b1;
         end
         default: begin
            mode_in = sclx_pkg::MODE_IDLE;
         end
      endcase

      // Word body: a quoted word runs to the closing quote, a bare word ends
      // at the first byte that cannot belong to it, which is then classified.
      word_kind = is_variable_in ? sclx_pkg::KIND_VARIABLE : sclx_pkg::KIND_STRING;
      if (do_word) begin
         if (is_quoted_in) begin
            if (in_byte == sclx_pkg::CHAR_QUOTE) begin
               pre_valid = 1'b1;
               pre_rec   = make_rec(word_kind, 32'd0, offset16(text_begin_in),
                                    offset16(pos), sclx_pkg::ERR_NONE, 8'd0);
               mode_in   = sclx_pkg::MODE_TOP;
            end else if (in_byte == sclx_pkg::CHAR_NUL) begin
               pre_valid = 1'b1;
               pre_rec   = make_rec(sclx_pkg::KIND_ERROR, 32'd0, 16'd0, 16'd0,
                                    sclx_pkg::ERR_UNTERMINATED, 8'd0);
               mode_in   = sclx_pkg::MODE_IDLE;
            end
         end else if (!is_word_byte(in_byte, 1'b1)) begin
            pre_valid   = 1'b1;
            pre_rec     = make_rec(word_kind, 32'd0, offset16(text_begin_in),
                                   offset16(pos), sclx_pkg::ERR_NONE, 8'd0);
            mode_in     = sclx_pkg::MODE_TOP;
            do_classify = 1'b1;
         end
      end

      if (do_classify) begin
         if (in_byte == sclx_pkg::CHAR_SPACE || in_byte == sclx_pkg::CHAR_LF ||
             in_byte == sclx_pkg::CHAR_TAB) begin
            cls_valid = 1'b0;
         end else if (in_byte == sclx_pkg::CHAR_LPAREN) begin
            cls_valid = 1'b1;
            cls_rec.kind = sclx_pkg::KIND_LPAREN;
         end else if (in_byte == sclx_pkg::CHAR_RPAREN) begin
            cls_valid = 1'b1;
            cls_rec.kind = sclx_pkg::KIND_RPAREN;
         end else if (in_byte == sclx_pkg::CHAR_LSQUARE) begin
            cls_valid = 1'b1;
            cls_rec.kind = sclx_pkg::KIND_LSQUARE;
         end else if (in_byte == sclx_pkg::CHAR_RSQUARE) begin
            cls_valid = 1'b1;
            cls_rec.kind = sclx_pkg::KIND_RSQUARE;
         end else if (is_digit) begin
            mode_in  = sclx_pkg::MODE_NUMBER;
            accum_in = {28'd0, in_byte[3:0]};
         end else if (in_byte == sclx_pkg::CHAR_NUL) begin
            cls_valid = 1'b1;
            cls_rec.kind = sclx_pkg::KIND_END;
            mode_in = sclx_pkg::MODE_IDLE;
         end else if (in_byte == sclx_pkg::CHAR_QUOTE) begin
            mode_in        = sclx_pkg::MODE_WORD;
            is_quoted_in   = 1'b1;
            is_variable_in = 1'b0;
            text_begin_in  = pos + 1'b1;
         end else if (is_word_byte(in_byte, 1'b0)) begin
            mode_in        = sclx_pkg::MODE_WORD;
            is_quoted_in   = 1'b0;
            is_variable_in = 1'b0;
            text_begin_in  = pos;
         end else if (in_byte == sclx_pkg::CHAR_DOLLAR) begin
            mode_in        = sclx_pkg::MODE_DOLLAR;
            is_variable_in = 1'b1;
         end else if (in_byte == sclx_pkg::CHAR_SEMI) begin
            cls_valid = 1'b1;
            cls_rec.kind = sclx_pkg::KIND_SEMICOLON;
         end else begin
            cls_valid = 1'b1;
            cls_rec   = make_rec(sclx_pkg::KIND_ERROR, 32'd0, 16'd0, 16'd0,
                                 sclx_pkg::ERR_UNKNOWN, in_byte);
            mode_in   = sclx_pkg::MODE_IDLE;
         end
      end

      position_in = pos + 1'b1;

      // The pending token, if any, always goes out before the classified one.
      push.count  = {pre_valid & cls_valid, pre_valid ^ cls_valid};
      push.first  = pre_valid ? pre_rec : cls_rec;
      push.first.last_of_run = !(pre_valid && cls_valid);
      push.second = cls_rec;
      push.second.last_of_run = 1'b1;
      if (!in_accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= sclx_pkg::MODE_IDLE;
         accum_ff       <= 32'd0;
         text_begin_ff  <= '0;
         position_ff    <= '0;
         is_variable_ff <= 1'b0;
         is_quoted_ff   <= 1'b0;
      end else if (in_accept) begin
         mode_ff        <= mode_in;
         accum_ff       <= accum_in;
         text_begin_ff  <= text_begin_in;
         position_ff    <= position_in;
         is_variable_ff <= is_variable_in;
         is_quoted_ff   <= is_quoted_in;
      end
   end

   // A new program always opens with its start token.
   assert property (@(posedge clock) disable iff (reset)
      in_accept && mode_ff == sclx_pkg::MODE_IDLE |->
         push.count != 2'd0 && push.first.kind == sclx_pkg::KIND_START)
      else $error("first byte of a program did not yield a start token");

   // After an end or error token the lexer waits for a new program.
   assert property (@(posedge clock) disable iff (reset)
      in_accept && push.count != 2'd0 &&
      (push.first.kind == sclx_pkg::KIND_END || push.first.kind == sclx_pkg::KIND_ERROR) &&
      push.first.last_of_run |=> mode_ff == sclx_pkg::MODE_IDLE)
      else $error("lexer did not return to idle after end or error");

   // The position counter advances by one for every accepted byte after a program's first.
   assert property (@(posedge clock) disable iff (reset)
      in_accept && mode_ff != sclx_pkg::MODE_IDLE |=>
         position_ff == $past(position_ff) + 1'b1)
      else $error("byte position did not advance");

endmodule

`default_nettype wire

// ----- design/sclx_result_queue.sv -----
// ----------------------------------------------------------------------------
// Script lexer result queue
// Small register queue that takes up to two tokens a cycle and hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module sclx_result_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sclx_pkg::push_type push,
   input  wire logic               pop,
   output sclx_pkg::result_type    head,
   output logic                    head_valid,
   output logic                    has_room
);

   sclx_pkg::result_type                      entry_ff [sclx_pkg::QUEUE_DEPTH];
   logic [sclx_pkg::QUEUE_PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [sclx_pkg::QUEUE_PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [sclx_pkg::QUEUE_CNT_BITS-1:0]       count_ff, count_in;
   logic [sclx_pkg::QUEUE_PTR_BITS-1:0]       wr_next;
   logic                                      do_pop;

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   // Room for the worst case of two tokens from one byte.
   assign has_room   = (count_ff <= sclx_pkg::QUEUE_CNT_BITS'(sclx_pkg::QUEUE_DEPTH - 2));
   assign do_pop     = pop && head_valid;
   assign wr_next    = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + sclx_pkg::QUEUE_PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + sclx_pkg::QUEUE_PTR_BITS'(do_pop);
      count_in  = count_ff + sclx_pkg::QUEUE_CNT_BITS'(push.count)
                  - sclx_pkg::QUEUE_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= sclx_pkg::QUEUE_CNT_BITS'(sclx_pkg::QUEUE_DEPTH))
      else $error("result queue occupancy out of range");

   assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |->
         count_ff + sclx_pkg::QUEUE_CNT_BITS'(push.count) <=
         sclx_pkg::QUEUE_CNT_BITS'(sclx_pkg::QUEUE_DEPTH))
      else $error("tokens pushed into a full result queue");

endmodule

`default_nettype wire

// ----- design/script_lexer_byte_stream_unit.sv -----
// ----------------------------------------------------------------------------
// Script lexer, byte stream unit
// Lexes a script program fed one byte per beat and streams out its tokens.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata (lowest bit first)                      | tlast
//  req_    | in        | char_byte[7:0]                                | -
//  rsp_    | out       | token_kind[3:0], number_value[35:4],          | last_of_run
//          |           | text_start[51:36], text_end[67:52],           |
//          |           | error_code[69:68], bad_char[77:70], zero pad  |
//
//  One byte is taken per clock while req_tready is high; its tokens enter the
//  registered result queue behind older ones. Two tokens from one byte take
//  a beat each; the single output port sets a rate of one beat per token.
//  A four-entry result queue decouples the sides; req_tready drops while
//  fewer than two entries are free. Reset leaves the lexer awaiting a new
//  program and the queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module script_lexer_byte_stream_unit #(
   parameter int unsigned POSITION_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // char_byte[7:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // kind, number, start, end, error, bad byte
   output logic             rsp_tlast
);

   sclx_pkg::push_type   push;
   sclx_pkg::result_type head;
   logic                 head_valid;
   logic                 has_room;
   logic                 in_accept;

   assign req_tready = has_room;
   assign in_accept  = req_tvalid && has_room;

   sclx_lexer #(
      .POSITION_BITS (POSITION_BITS)
   ) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_byte   (req_tdata),
      .push      (push)
   );

   sclx_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_tready),
      .head       (head),
      .head_valid (head_valid),
      .has_room   (has_room)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tlast  = head.last_of_run;
   assign rsp_tdata  = {2'b00, head.bad_char, head.error_code, head.text_end,
                        head.text_start, head.number_value, head.kind};

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Script lexer byte stream unit testbench
// Feeds program bytes on req_, predicts every token with an independent lexer
// model kept alongside the stream, and checks each rsp_ beat field by field
// against the oldest predicted token. Runs directed byte sequences, then
// random programs under several idling mixes and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sclx_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int MAX_PRINTED    = 20;
   localparam int PHASE_ITEMS    = 360;

   typedef struct {
      token_kind_type kind;
      logic [31:0]    number;
      logic [15:0]    tstart;
      logic [15:0]    tend;
      error_code_type err;
      logic [7:0]     bad;
      logic           last;
   } token_rec_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // char_byte[7:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;            // token_kind, number_value, text_start, text_end,
                                      // error_code, bad_char, zero pad
   logic        rsp_tlast;            // last_of_run

   script_lexer_byte_stream_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   logic [7:0] program_bytes [$];
   token_rec_type pending_tokens [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_asked     = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int stall_cycles   = 0;
   int mismatch_count = 0;
   int items_queued   = 0;
   int bytes_fed      = 0;
   int tokens_checked = 0;
   int programs_built = 0;
   logic [10:0] kinds_seen = '0;

   // Lexer state as the block should hold it.
   lex_mode_type lx_mode   = MODE_IDLE;
   logic [31:0]  lx_accum  = '0;
   logic [15:0]  lx_begin  = '0;
   logic [15:0]  lx_pos    = '0;
   logic         lx_var    = 1'b0;
   logic         lx_quoted = 1'b0;
   int           lx_emitted;

   task automatic note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   function automatic void queue_token(token_kind_type k, logic [31:0] n, logic [15:0] ts,
                                       logic [15:0] te, error_code_type e, logic [7:0] b);
      token_rec_type t;
      if (lx_emitted >= 2) return;
      t.kind   = k;
      t.number = n;
      t.tstart = ts;
      t.tend   = te;
      t.err    = e;
      t.bad    = b;
      t.last   = 1'b0;
      pending_tokens.push_back(t);
      lx_emitted++;
   endfunction

   function automatic logic is_word_char(logic [7:0] c, logic digits_ok);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_PERCENT && c <= CHAR_SLASH && c != CHAR_LPAREN &&
              c != CHAR_RPAREN) ||
             c == CHAR_COLON || (c >= CHAR_LT && c <= CHAR_AT) ||
             (digits_ok && c >= CHAR_ZERO && c <= CHAR_NINE);
   endfunction

   function automatic void classify_char(logic [7:0] c, logic [15:0] pos);
      if (c == CHAR_SPACE || c == CHAR_LF || c == CHAR_TAB) begin
         return;
      end else if (c == CHAR_LPAREN) begin
         queue_token(KIND_LPAREN, '0, '0, '0, ERR_NONE, '0);
      end else if (c == CHAR_RPAREN) begin
         queue_token(KIND_RPAREN, '0, '0, '0, ERR_NONE, '0);
      end else if (c == CHAR_LSQUARE) begin
         queue_token(KIND_LSQUARE, '0, '0, '0, ERR_NONE, '0);
      end else if (c == CHAR_RSQUARE) begin
         queue_token(KIND_RSQUARE, '0, '0, '0, ERR_NONE, '0);
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         lx_mode  = MODE_NUMBER;
         lx_accum = {24'd0, c - CHAR_ZERO};
      end else if (c == CHAR_NUL) begin
         queue_token(KIND_END, '0, '0, '0, ERR_NONE, '0);
         lx_mode = MODE_IDLE;
      end else if (c == CHAR_QUOTE) begin
         lx_mode   = MODE_WORD;
         lx_quoted = 1'b1;
         lx_var    = 1'b0;
         lx_begin  = pos + 16'd1;
      end else if (is_word_char(c, 1'b0)) begin
         lx_mode   = MODE_WORD;
         lx_quoted = 1'b0;
         lx_var    = 1'b0;
         lx_begin  = pos;
      end else if (c == CHAR_DOLLAR) begin
         lx_mode = MODE_DOLLAR;
         lx_var  = 1'b1;
      end else if (c == CHAR_SEMI) begin
         queue_token(KIND_SEMICOLON, '0, '0, '0, ERR_NONE, '0);
      end else begin
         queue_token(KIND_ERROR, '0, '0, '0, ERR_UNKNOWN, c);
         lx_mode = MODE_IDLE;
      end
   endfunction

   function automatic void word_char(logic [7:0] c, logic [15:0] pos);
      token_kind_type k;
      k = lx_var ? KIND_VARIABLE : KIND_STRING;
      if (lx_quoted) begin
         if (c == CHAR_QUOTE) begin
            queue_token(k, '0, lx_begin, pos, ERR_NONE, '0);
            lx_mode = MODE_TOP;
         end else if (c == CHAR_NUL) begin
            queue_token(KIND_ERROR, '0, '0, '0, ERR_UNTERMINATED, '0);
            lx_mode = MODE_IDLE;
         end
         return;
      end
      if (is_word_char(c, 1'b1)) return;
      queue_token(k, '0, lx_begin, pos, ERR_NONE, '0);
      lx_mode = MODE_TOP;
      classify_char(c, pos);
   endfunction

   // Advances the lexer state by one accepted byte and queues its tokens.
   function automatic void lex_byte(logic [7:0] c);
      lx_emitted = 0;
      if (lx_mode == MODE_IDLE) begin
         lx_pos    = '0;
         lx_quoted = 1'b0;
         lx_var    = 1'b0;
         lx_accum  = '0;
         queue_token(KIND_START, '0, '0, '0, ERR_NONE, '0);
         lx_mode = MODE_TOP;
         classify_char(c, 16'd0);
      end else begin
         case (lx_mode)
            MODE_NUMBER: begin
               if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                  lx_accum = lx_accum * 32'd10 + {24'd0, c - CHAR_ZERO};
               end else begin
                  queue_token(KIND_NUMBER, lx_accum, '0, '0, ERR_NONE, '0);
                  lx_mode = MODE_TOP;
                  classify_char(c, lx_pos);
               end
            end
            MODE_WORD: begin
               word_char(c, lx_pos);
            end
            MODE_DOLLAR: begin
               lx_mode = MODE_WORD;
               if (c == CHAR_QUOTE) begin
                  lx_quoted = 1'b1;
                  lx_begin  = lx_pos + 16'd1;
               end else begin
                  lx_quoted = 1'b0;
                  lx_begin  = lx_pos;
                  word_char(c, lx_pos);
               end
            end
            default: begin
               lx_mode = MODE_TOP;
               classify_char(c, lx_pos);
            end
         endcase
      end
      lx_pos = lx_pos + 16'd1;
      if (lx_emitted > 0) pending_tokens[pending_tokens.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic [7:0] pick_space();
      case ($urandom_range(0, 2))
         0: return CHAR_SPACE;
         1: return CHAR_LF;
         default: return CHAR_TAB;
      endcase
   endfunction

   function automatic logic [7:0] pick_word_start();
      logic [7:0] punct [15];
      punct = '{8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
                8'h3A, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40};
      case ($urandom_range(0, 3))
         0: return CHAR_LOWER_A + 8'($urandom_range(0, 25));
         1: return CHAR_UPPER_A + 8'($urandom_range(0, 25));
         default: return punct[$urandom_range(0, 14)];
      endcase
   endfunction

   function automatic logic [7:0] pick_quoted();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CHAR_QUOTE);
      return b;
   endfunction

   task automatic push_byte(logic [7:0] b);
      program_bytes.push_back(b);
      items_queued++;
   endtask

   task automatic push_word();
      int n;
      push_byte(pick_word_start());
      n = $urandom_range(0, 6);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
         else push_byte(pick_word_start());
      end
   endtask

   task automatic push_quoted();
      int n;
      push_byte(CHAR_QUOTE);
      n = $urandom_range(0, 7);
      repeat (n) push_byte(pick_quoted());
      push_byte(CHAR_QUOTE);
   endtask

   // One program of random tokens, mostly well formed, ending in NUL or breakage.
   task automatic add_program();
      int ntok, shape, len;
      ntok = $urandom_range(1, 12);
      programs_built++;
      repeat (ntok) begin
         shape = $urandom_range(0, 99);
         if (shape < 20) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
            repeat (len) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
         end else if (shape < 38) begin
            push_word();
         end else if (shape < 50) begin
            push_quoted();
         end else if (shape < 60) begin
            push_byte(CHAR_DOLLAR);
            case ($urandom_range(0, 2))
               0: push_word();
               1: push_quoted();
               default: ;
            endcase
         end else if (shape < 85) begin
            case ($urandom_range(0, 4))
               0: push_byte(CHAR_LPAREN);
               1: push_byte(CHAR_RPAREN);
               2: push_byte(CHAR_LSQUARE);
               3: push_byte(CHAR_RSQUARE);
               default: push_byte(CHAR_SEMI);
            endcase
         end else if (shape < 93) begin
            repeat ($urandom_range(1, 3)) push_byte(pick_space());
         end else begin
            push_byte(8'($urandom_range(1, 255)));
         end
         if ($urandom_range(0, 99) < 55) push_byte(pick_space());
      end
      shape = $urandom_range(0, 99);
      if (shape < 80) begin
         push_byte(CHAR_NUL);
      end else if (shape < 90) begin
         // A byte no class accepts ends the program with an error.
         push_byte($urandom_range(0, 1) ? 8'h0D : (8'h80 | 8'($urandom_range(0, 127))));
      end else begin
         push_byte(CHAR_QUOTE);
         repeat ($urandom_range(0, 4)) push_byte(pick_quoted());
         push_byte(CHAR_NUL);
      end
   endtask

   task automatic wait_drained();
      while (program_bytes.size() != 0 || req_tvalid || pending_tokens.size() != 0)
         @(negedge clock);
   endtask

   task automatic feed_phase(int target);
      int first;
      first = items_queued;
      while (items_queued - first < target) add_program();
      wait_drained();
   endtask

   // ------------------------------------------------------------------ driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= CHAR_NUL;
      end else begin
         if (req_tvalid && req_tready) begin
            lex_byte(req_tdata);
            bytes_fed++;
         end
         if (!req_tvalid || req_tready) begin
            if (program_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= program_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ----------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin : take_beat
            token_rec_type got, want;
            got.kind   = token_kind_type'(rsp_tdata[3:0]);
            got.number = rsp_tdata[35:4];
            got.tstart = rsp_tdata[51:36];
            got.tend   = rsp_tdata[67:52];
            got.err    = error_code_type'(rsp_tdata[69:68]);
            got.bad    = rsp_tdata[77:70];
            got.last   = rsp_tlast;
            tokens_checked++;
            if (got.kind <= KIND_SEMICOLON) kinds_seen[got.kind] = 1'b1;
            if (pending_tokens.size() == 0) begin
               note_mismatch($sformatf("unexpected token, kind %0d", got.kind));
            end else begin
               want = pending_tokens.pop_front();
               if (got.kind !== want.kind)
                  note_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
               if (got.number !== want.number)
                  note_mismatch($sformatf("number %0d, want %0d", got.number, want.number));
               if (got.tstart !== want.tstart)
                  note_mismatch($sformatf("text_start %0d, want %0d", got.tstart, want.tstart));
               if (got.tend !== want.tend)
                  note_mismatch($sformatf("text_end %0d, want %0d", got.tend, want.tend));
               if (got.err !== want.err)
                  note_mismatch($sformatf("error_code %0d, want %0d", got.err, want.err));
               if (got.bad !== want.bad)
                  note_mismatch($sformatf("bad_char %0h, want %0h", got.bad, want.bad));
               if (got.last !== want.last)
                  note_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
            end
         end
         if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // A run that stops moving beats on both sides is hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles, %0d tokens outstanding",
                  stall_cycles, pending_tokens.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // --------------------------------------------------------------- sequence

   initial begin
      logic [7:0] directed [24];
      directed = '{CHAR_LPAREN, CHAR_RPAREN, CHAR_LSQUARE, CHAR_RSQUARE, CHAR_SEMI, CHAR_TAB,
                   8'h37, CHAR_LOWER_A, CHAR_LF, CHAR_DOLLAR, CHAR_RPAREN,
                   CHAR_QUOTE, 8'hFF, CHAR_QUOTE, CHAR_DOLLAR, CHAR_QUOTE, 8'h78, CHAR_QUOTE,
                   8'h0D, 8'h78, 8'h80, CHAR_QUOTE, CHAR_NUL, CHAR_NUL};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed bytes: every token kind, first-byte pairs, empty variable,
      // quoted variable, unknown bytes and an unterminated quote.
      foreach (directed[i]) push_byte(directed[i]);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      feed_phase(PHASE_ITEMS);

      send_idle_pct = 57;
      feed_phase(PHASE_ITEMS);

      send_idle_pct  = 0;
      recv_stall_pct = 57;
      feed_phase(PHASE_ITEMS);

      send_idle_pct  = 12;
      recv_stall_pct = 12;
      feed_phase(PHASE_ITEMS);

      // The receiver holds off while bytes keep coming, so the block backs up.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_asked++;
      feed_phase(PHASE_ITEMS);

      repeat (20) @(negedge clock);
      if (pending_tokens.size() != 0)
         note_mismatch($sformatf("%0d tokens never arrived", pending_tokens.size()));
      $display("Lexed %0d bytes in %0d programs under four idling mixes and a hold-off.",
               bytes_fed, programs_built);
      $display("Checked %0d tokens; kinds seen (bit per kind) %b; %0d mismatches.",
               tokens_checked, kinds_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
